[design/sts_pkg.sv]
package sts_pkg;

  localparam int NUM_TASKS = 16;
  localparam int NUM_PRIOS = 32;
  localparam int TW = $clog2(NUM_TASKS);
  localparam int PW = $clog2(NUM_PRIOS);
  localparam int CW = $clog2(NUM_TASKS + 1);

  localparam logic [7:0] SAT_MAX     = 8'd255;
  localparam logic [7:0] SLICE_RESET = 8'd10;

  localparam logic [3:0] ACT_CREATE    = 4'd0;
  localparam logic [3:0] ACT_TICK      = 4'd1;
  localparam logic [3:0] ACT_DELAY     = 4'd2;
  localparam logic [3:0] ACT_SUSPEND   = 4'd3;
  localparam logic [3:0] ACT_RESUME    = 4'd4;
  localparam logic [3:0] ACT_LOCK      = 4'd5;
  localparam logic [3:0] ACT_UNLOCK    = 4'd6;
  localparam logic [3:0] ACT_UNLOCK_NS = 4'd7;
  localparam logic [3:0] ACT_START     = 4'd8;
  localparam logic [3:0] ACT_SCHEDULE  = 4'd9;

  typedef logic [TW-1:0] task_t;
  typedef logic [PW-1:0] prio_t;
  typedef logic [CW-1:0] cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RUN
  } state_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_LATCH,
    CMD_EXEC,
    CMD_REM_STEP,
    CMD_TICK_STEP,
    CMD_SLICE,
    CMD_SCHED,
    CMD_FINISH
  } cmd_t;

  typedef struct packed {
    logic rem_pend;
    logic walk_pend;
    logic slice_pend;
    logic sched_pend;
  } status_t;

endpackage

[design/sts_ctrl.sv]
module sts_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             out_stall,
  output logic             out_valid,
  input  sts_pkg::status_t st,
  output sts_pkg::cmd_t    cmd
);
  import sts_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NOP;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LATCH;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd       = CMD_EXEC;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (st.rem_pend) begin
          cmd = CMD_REM_STEP;
        end else if (st.walk_pend) begin
          cmd = CMD_TICK_STEP;
        end else if (st.slice_pend) begin
          cmd = CMD_SLICE;
        end else if (st.sched_pend) begin
          cmd = CMD_SCHED;
        end else if (!out_valid_r || !out_stall) begin
          cmd       = CMD_FINISH;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = (cmd == CMD_FINISH) | (out_valid_r & out_stall);
  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;

endmodule

[design/sts_dp.sv]
module sts_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  sts_pkg::cmd_t    cmd,
  output sts_pkg::status_t st,
  input  logic [3:0]       in_action,
  input  logic [3:0]       in_task_id,
  input  logic [4:0]       in_task_prio,
  input  logic [15:0]      in_delay_ticks,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data,
  output logic [3:0]       out_next_task,
  output logic             out_switch_request,
  output logic             out_none_ready,
  output logic [7:0]       out_lock_level
);
  import sts_pkg::*;

  logic [7:0]           slice_len_r;
  logic [NUM_PRIOS-1:0] ready_bits_r;
  task_t                q_head_r [NUM_PRIOS];
  task_t                q_tail_r [NUM_PRIOS];
  cnt_t                 q_cnt_r  [NUM_PRIOS];
  task_t                rlink_r  [NUM_TASKS];
  task_t                wlink_r  [NUM_TASKS];
  task_t                w_head_r, w_tail_r;
  cnt_t                 w_cnt_r;
  prio_t                prio_r   [NUM_TASKS];
  logic [15:0]          cd_r     [NUM_TASKS];
  logic [7:0]           slice_r  [NUM_TASKS];
  logic [7:0]           depth_r  [NUM_TASKS];
  logic [NUM_TASKS-1:0] live_r, dly_r, susp_r;
  task_t                cur_r;
  logic [7:0]           lock_r;

  logic [3:0]  act_r;
  task_t       id_r;
  logic        id_ok_r;
  prio_t       aprio_r;
  logic [15:0] ticks_r;

  logic  rem_pend_r, walk_pend_r, slice_pend_r, sched_pend_r, sw_r;
  task_t rem_tgt_r, rem_cur_r, rem_prev_r;
  prio_t rem_p_r;
  logic  rem_first_r;
  task_t wk_cur_r, wk_prev_r;
  logic  wk_has_prev_r;
  cnt_t  wk_left_r;

  logic [3:0] o_next_r;
  logic       o_sw_r, o_none_r;
  logic [7:0] o_lock_r;

  logic  any;
  prio_t best;
  task_t best_task;
  logic  push_en;
  task_t push_t;
  prio_t push_p;
  prio_t cur_p;
  prio_t id_p;
  logic  cur_ready;
  task_t wk_nxt;
  logic [15:0] wk_ncd;
  logic [7:0]  rs_depth;

  always_comb begin
    any  = 1'b0;
    best = '0;
    for (int p = NUM_PRIOS - 1; p >= 0; p--) begin
      if (ready_bits_r[p]) begin
        any  = 1'b1;
        best = PW'(p);
      end
    end
  end

  assign best_task = q_head_r[best];
  assign cur_p     = prio_r[cur_r];
  assign id_p      = prio_r[id_r];
  assign cur_ready = live_r[cur_r] & ~dly_r[cur_r] & ~susp_r[cur_r];
  assign wk_nxt    = wlink_r[wk_cur_r];
  assign wk_ncd    = (cd_r[wk_cur_r] != 16'd0) ? cd_r[wk_cur_r] - 16'd1 : 16'd0;
  assign rs_depth  = (depth_r[id_r] != 8'd0) ? depth_r[id_r] - 8'd1 : 8'd0;

  always_comb begin
    push_en = 1'b0;
    push_t  = id_r;
    push_p  = aprio_r;
    case (cmd)
      CMD_EXEC: begin
        if (act_r == ACT_CREATE && id_ok_r && !live_r[id_r]) begin
          push_en = 1'b1;
        end else if (act_r == ACT_RESUME && id_ok_r && live_r[id_r] && susp_r[id_r] &&
                     rs_depth == 8'd0) begin
          push_en = 1'b1;
          push_p  = id_p;
        end
      end
      CMD_TICK_STEP: begin
        if (wk_ncd == 16'd0) begin
          push_en = 1'b1;
          push_t  = wk_cur_r;
          push_p  = prio_r[wk_cur_r];
        end
      end
      default: push_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_len_r  <= SLICE_RESET;
      ready_bits_r <= '0;
      for (int p = 0; p < NUM_PRIOS; p++) q_cnt_r[p] <= '0;
      w_head_r     <= '0;
      w_tail_r     <= '0;
      w_cnt_r      <= '0;
      live_r       <= '0;
      dly_r        <= '0;
      susp_r       <= '0;
      cur_r        <= '0;
      lock_r       <= '0;
      rem_pend_r   <= 1'b0;
      walk_pend_r  <= 1'b0;
      slice_pend_r <= 1'b0;
      sched_pend_r <= 1'b0;
      sw_r         <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        slice_len_r <= cfg_wr_data;
      end
      case (cmd)
        CMD_LATCH: begin
          act_r   <= in_action;
          id_r    <= TW'(in_task_id);
          id_ok_r <= (32'(in_task_id) < NUM_TASKS);
          aprio_r <= (32'(in_task_prio) >= NUM_PRIOS) ? PW'(NUM_PRIOS - 1) : PW'(in_task_prio);
          ticks_r <= in_delay_ticks;
          sw_r    <= 1'b0;
        end
        CMD_EXEC: begin
          unique case (act_r)
            ACT_CREATE: begin
              if (id_ok_r && !live_r[id_r]) begin
                live_r[id_r]  <= 1'b1;
                prio_r[id_r]  <= aprio_r;
                cd_r[id_r]    <= 16'd0;
                slice_r[id_r] <= slice_len_r;
                depth_r[id_r] <= 8'd0;
                dly_r[id_r]   <= 1'b0;
                susp_r[id_r]  <= 1'b0;
              end
            end
            ACT_TICK: begin
              wk_cur_r      <= w_head_r;
              wk_prev_r     <= '0;
              wk_has_prev_r <= 1'b0;
              wk_left_r     <= w_cnt_r;
              walk_pend_r   <= (w_cnt_r != '0);
              slice_pend_r  <= 1'b1;
            end
            ACT_DELAY: begin
              if (cur_ready) begin
                cd_r[cur_r] <= (ticks_r == 16'd0) ? 16'd1 : ticks_r;
                if (w_cnt_r == '0) begin
                  w_head_r <= cur_r;
                end else begin
                  wlink_r[w_tail_r] <= cur_r;
                end
                w_tail_r     <= cur_r;
                w_cnt_r      <= w_cnt_r + cnt_t'(1);
                dly_r[cur_r] <= 1'b1;
                rem_tgt_r    <= cur_r;
                rem_p_r      <= cur_p;
                rem_cur_r    <= q_head_r[cur_p];
                rem_prev_r   <= '0;
                rem_first_r  <= 1'b1;
                rem_pend_r   <= 1'b1;
                sched_pend_r <= 1'b1;
              end
            end
            ACT_SUSPEND: begin
              if (id_ok_r && live_r[id_r] && !dly_r[id_r]) begin
                if (depth_r[id_r] == 8'd0) begin
                  depth_r[id_r] <= 8'd1;
                  susp_r[id_r]  <= 1'b1;
                  rem_tgt_r     <= id_r;
                  rem_p_r       <= id_p;
                  rem_cur_r     <= q_head_r[id_p];
                  rem_prev_r    <= '0;
                  rem_first_r   <= 1'b1;
                  rem_pend_r    <= 1'b1;
                  sched_pend_r  <= (id_r == cur_r);
                end else if (depth_r[id_r] < SAT_MAX) begin
                  depth_r[id_r] <= depth_r[id_r] + 8'd1;
                end
              end
            end
            ACT_RESUME: begin
              if (id_ok_r && live_r[id_r] && susp_r[id_r]) begin
                depth_r[id_r] <= rs_depth;
                if (rs_depth == 8'd0) begin
                  susp_r[id_r] <= 1'b0;
                  sched_pend_r <= 1'b1;
                end
              end
            end
            ACT_LOCK: begin
              if (lock_r < SAT_MAX) lock_r <= lock_r + 8'd1;
            end
            ACT_UNLOCK: begin
              if (lock_r != 8'd0) begin
                lock_r       <= lock_r - 8'd1;
                sched_pend_r <= (lock_r == 8'd1);
              end
            end
            ACT_UNLOCK_NS: begin
              if (lock_r != 8'd0) lock_r <= lock_r - 8'd1;
            end
            ACT_START: begin
              if (any) begin
                cur_r <= best_task;
                sw_r  <= 1'b1;
              end
              if (lock_r != 8'd0) lock_r <= lock_r - 8'd1;
            end
            ACT_SCHEDULE: sched_pend_r <= 1'b1;
            default: sw_r <= 1'b0;
          endcase
        end
        CMD_REM_STEP: begin
          if (rem_cur_r == rem_tgt_r) begin
            if (rem_first_r) begin
              q_head_r[rem_p_r] <= rlink_r[rem_cur_r];
            end else begin
              rlink_r[rem_prev_r] <= rlink_r[rem_cur_r];
            end
            if (q_tail_r[rem_p_r] == rem_cur_r) q_tail_r[rem_p_r] <= rem_prev_r;
            q_cnt_r[rem_p_r] <= q_cnt_r[rem_p_r] - cnt_t'(1);
            if (q_cnt_r[rem_p_r] == cnt_t'(1)) ready_bits_r[rem_p_r] <= 1'b0;
            rem_pend_r <= 1'b0;
          end else begin
            rem_prev_r  <= rem_cur_r;
            rem_cur_r   <= rlink_r[rem_cur_r];
            rem_first_r <= 1'b0;
          end
        end
        CMD_TICK_STEP: begin
          cd_r[wk_cur_r] <= wk_ncd;
          if (wk_ncd == 16'd0) begin
            if (!wk_has_prev_r) begin
              w_head_r <= wk_nxt;
            end else begin
              wlink_r[wk_prev_r] <= wk_nxt;
            end
            if (w_tail_r == wk_cur_r) w_tail_r <= wk_prev_r;
            w_cnt_r         <= w_cnt_r - cnt_t'(1);
            dly_r[wk_cur_r] <= 1'b0;
          end else begin
            wk_prev_r     <= wk_cur_r;
            wk_has_prev_r <= 1'b1;
          end
          wk_cur_r  <= wk_nxt;
          wk_left_r <= wk_left_r - cnt_t'(1);
          if (wk_left_r == cnt_t'(1)) walk_pend_r <= 1'b0;
        end
        CMD_SLICE: begin
          slice_pend_r <= 1'b0;
          if (live_r[cur_r]) begin
            if (slice_r[cur_r] > 8'd1) begin
              slice_r[cur_r] <= slice_r[cur_r] - 8'd1;
            end else begin
              slice_r[cur_r] <= slice_len_r;
              if (cur_ready && q_cnt_r[cur_p] > cnt_t'(1) && q_head_r[cur_p] == cur_r) begin
                q_head_r[cur_p]          <= rlink_r[cur_r];
                rlink_r[q_tail_r[cur_p]] <= cur_r;
                q_tail_r[cur_p]          <= cur_r;
              end
            end
          end
        end
        CMD_SCHED: begin
          sched_pend_r <= 1'b0;
          if (lock_r == 8'd0 && any && best_task != cur_r) begin
            cur_r <= best_task;
            sw_r  <= 1'b1;
          end
        end
        CMD_FINISH: begin
          o_next_r <= any ? 4'(best_task) : 4'd0;
          o_sw_r   <= sw_r;
          o_none_r <= ~any;
          o_lock_r <= lock_r;
        end
        default: sw_r <= sw_r;
      endcase
      if (push_en) begin
        if (q_cnt_r[push_p] == '0) begin
          q_head_r[push_p] <= push_t;
        end else begin
          rlink_r[q_tail_r[push_p]] <= push_t;
        end
        q_tail_r[push_p]     <= push_t;
        q_cnt_r[push_p]      <= q_cnt_r[push_p] + cnt_t'(1);
        ready_bits_r[push_p] <= 1'b1;
      end
    end
  end

  assign st.rem_pend   = rem_pend_r;
  assign st.walk_pend  = walk_pend_r;
  assign st.slice_pend = slice_pend_r;
  assign st.sched_pend = sched_pend_r;

  assign out_next_task      = o_next_r;
  assign out_switch_request = o_sw_r;
  assign out_none_ready     = o_none_r;
  assign out_lock_level     = o_lock_r;

endmodule

[design/static_priority_task_scheduler.sv]
// Task scheduler with one FIFO ready queue per priority (priority 0 is
// highest), a delay list with tick countdowns, time slices, suspend depths
// and a saturating lock count. One item is taken at a time and gives one
// result: a latch step and an execute step, then one step per queue entry
// walked to unlink a delayed or suspended task, one per delay-list entry
// and one slice step on a tick, and a scheduling step before the result.
// The walks step one list link a cycle through the controller loop.
// The result register frees the input side while a result waits.
module static_priority_task_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_action,
  input  logic [3:0]  in_task_id,
  input  logic [4:0]  in_task_prio,
  input  logic [15:0] in_delay_ticks,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_next_task,
  output logic        out_switch_request,
  output logic        out_none_ready,
  output logic [7:0]  out_lock_level,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import sts_pkg::*;

  cmd_t    cmd;
  status_t st;

  sts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .st        (st),
    .cmd       (cmd)
  );

  sts_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_action          (in_action),
    .in_task_id         (in_task_id),
    .in_task_prio       (in_task_prio),
    .in_delay_ticks     (in_delay_ticks),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .out_next_task      (out_next_task),
    .out_switch_request (out_switch_request),
    .out_none_ready     (out_none_ready),
    .out_lock_level     (out_lock_level)
  );

  a_finish_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_FINISH) |-> !(st.rem_pend || st.walk_pend || st.slice_pend || st.sched_pend))
    else $error("result issued with work pending");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !(st.rem_pend || st.walk_pend || st.slice_pend || st.sched_pend))
    else $error("idle with work pending");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_none_ready) |-> (out_next_task == 4'd0 && !out_switch_request))
    else $error("empty result names a task");

endmodule

[sim/static_priority_task_scheduler_tb.sv]
`timescale 1ns / 100ps

module static_priority_task_scheduler_tb;
  import sts_pkg::*;

  localparam int  CYCLE_LIMIT  = 1000000;
  localparam int  HOLD_CYCLES  = 300;
  localparam int  MAX_REPORTS  = 50;
  localparam logic [3:0] ACT_FIRST_NOOP = 4'd10;
  localparam logic [3:0] ACT_LAST_NOOP  = 4'd15;
  localparam logic [1:0] FLAG_DELAYED   = 2'b01;
  localparam logic [1:0] FLAG_SUSPENDED = 2'b10;

  typedef struct {
    logic [3:0] next_task;
    logic       switch_request;
    logic       none_ready;
    logic [7:0] lock_level;
  } sched_result_t;

  class sched_scoreboard;
    logic [31:0] ready_map;
    logic [3:0]  q_head[NUM_PRIOS];
    logic [3:0]  q_tail[NUM_PRIOS];
    int          q_len[NUM_PRIOS];
    logic [3:0]  r_link[NUM_TASKS];
    logic [3:0]  w_link[NUM_TASKS];
    logic [3:0]  w_head;
    logic [3:0]  w_tail;
    int          w_len;
    logic [4:0]  t_prio[NUM_TASKS];
    logic [15:0] t_wait[NUM_TASKS];
    logic [7:0]  t_slice[NUM_TASKS];
    logic [7:0]  t_susp[NUM_TASKS];
    logic [1:0]  t_flag[NUM_TASKS];
    bit          t_live[NUM_TASKS];
    logic [3:0]  running;
    logic [7:0]  locks;
    logic [7:0]  slice_len;
    sched_result_t due[$];
    int          errors;

    function new();
      ready_map = '0;
      foreach (q_head[p]) begin
        q_head[p] = '0;
        q_tail[p] = '0;
        q_len[p]  = 0;
      end
      foreach (r_link[t]) begin
        r_link[t]  = '0;
        w_link[t]  = '0;
        t_prio[t]  = '0;
        t_wait[t]  = '0;
        t_slice[t] = '0;
        t_susp[t]  = '0;
        t_flag[t]  = '0;
        t_live[t]  = 0;
      end
      w_head = '0;
      w_tail = '0;
      w_len = 0;
      running = '0;
      locks = '0;
      slice_len = SLICE_RESET;
      errors = 0;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function bit is_ready(int t);
      return t_live[t] && t_flag[t] == 2'b00;
    endfunction

    function void push_ready(int t);
      int p;
      p = t_prio[t];
      if (q_len[p] == 0) q_head[p] = 4'(t);
      else r_link[q_tail[p]] = 4'(t);
      q_tail[p] = 4'(t);
      q_len[p]++;
      ready_map[p] = 1'b1;
    endfunction

    function void unlink_ready(int t);
      int p;
      int c;
      int pv;
      p = t_prio[t];
      c = q_head[p];
      pv = 0;
      for (int i = 0; i < q_len[p]; i++) begin
        if (c == t) begin
          if (i == 0) q_head[p] = r_link[c];
          else r_link[pv] = r_link[c];
          if (q_tail[p] == c) q_tail[p] = 4'(pv);
          q_len[p]--;
          if (q_len[p] == 0) ready_map[p] = 1'b0;
          return;
        end
        pv = c;
        c = r_link[c];
      end
    endfunction

    function bit pick(output int t);
      for (int p = 0; p < NUM_PRIOS; p++) begin
        if (ready_map[p]) begin
          t = q_head[p];
          return 1;
        end
      end
      t = 0;
      return 0;
    endfunction

    function bit run_sched();
      int n;
      if (locks > 0 || !pick(n)) return 0;
      if (n != running) begin
        running = 4'(n);
        return 1;
      end
      return 0;
    endfunction

    function void tick_all();
      int c;
      int pv;
      int n;
      int nx;
      int p;
      bit hp;
      c = w_head;
      pv = 0;
      hp = 0;
      n = w_len;
      for (int i = 0; i < n; i++) begin
        nx = w_link[c];
        if (t_wait[c] > 0) t_wait[c]--;
        if (t_wait[c] == 0) begin
          if (!hp) w_head = 4'(nx);
          else w_link[pv] = 4'(nx);
          if (w_tail == c) w_tail = 4'(pv);
          w_len--;
          t_flag[c] &= ~FLAG_DELAYED;
          push_ready(c);
        end else begin
          pv = c;
          hp = 1;
        end
        c = nx;
      end
      c = running;
      if (!t_live[c]) return;
      if (t_slice[c] > 1) begin
        t_slice[c]--;
        return;
      end
      t_slice[c] = slice_len;
      if (is_ready(c)) begin
        p = t_prio[c];
        if (q_len[p] > 1 && q_head[p] == c) begin
          q_head[p] = r_link[c];
          q_len[p]--;
          push_ready(c);
        end
      end
    endfunction

    function void note_item(logic [3:0] act, logic [3:0] id, logic [4:0] prio,
                            logic [15:0] ticks);
      int n;
      int c;
      bit sw;
      sched_result_t r;
      sw = 0;
      c = running;
      case (act)
        ACT_CREATE: begin
          if (!t_live[id]) begin
            t_live[id]  = 1;
            t_prio[id]  = prio;
            t_wait[id]  = '0;
            t_slice[id] = slice_len;
            t_susp[id]  = '0;
            t_flag[id]  = '0;
            push_ready(id);
          end
        end
        ACT_TICK: tick_all();
        ACT_DELAY: begin
          if (is_ready(c)) begin
            t_wait[c] = (ticks == 0) ? 16'd1 : ticks;
            unlink_ready(c);
            if (w_len == 0) w_head = 4'(c);
            else w_link[w_tail] = 4'(c);
            w_tail = 4'(c);
            w_len++;
            t_flag[c] |= FLAG_DELAYED;
            sw = run_sched();
          end
        end
        ACT_SUSPEND: begin
          if (t_live[id] && (t_flag[id] & FLAG_DELAYED) == 0) begin
            if (t_susp[id] == 0) begin
              t_susp[id] = 8'd1;
              t_flag[id] |= FLAG_SUSPENDED;
              unlink_ready(id);
              if (id == running) sw = run_sched();
            end else if (t_susp[id] < SAT_MAX) begin
              t_susp[id]++;
            end
          end
        end
        ACT_RESUME: begin
          if (t_live[id] && (t_flag[id] & FLAG_SUSPENDED) != 0) begin
            if (t_susp[id] > 0) t_susp[id]--;
            if (t_susp[id] == 0) begin
              t_flag[id] &= ~FLAG_SUSPENDED;
              push_ready(id);
              sw = run_sched();
            end
          end
        end
        ACT_LOCK: if (locks < SAT_MAX) locks++;
        ACT_UNLOCK: begin
          if (locks > 0) begin
            locks--;
            if (locks == 0) sw = run_sched();
          end
        end
        ACT_UNLOCK_NS: if (locks > 0) locks--;
        ACT_START: begin
          if (pick(n)) begin
            running = 4'(n);
            sw = 1;
          end
          if (locks > 0) locks--;
        end
        ACT_SCHEDULE: sw = run_sched();
        default: ;
      endcase
      r.none_ready = !pick(n);
      r.next_task = 4'(n);
      r.switch_request = sw;
      r.lock_level = locks;
      due.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_result(logic [3:0] nt, logic sw, logic nr, logic [7:0] ll);
      sched_result_t e;
      if (due.size() == 0) begin
        report("result with no item outstanding");
        return;
      end
      e = due.pop_front();
      if (nt !== e.next_task)
        report($sformatf("next_task %0d, want %0d", nt, e.next_task));
      if (sw !== e.switch_request)
        report($sformatf("switch_request %0b, want %0b", sw, e.switch_request));
      if (nr !== e.none_ready)
        report($sformatf("none_ready %0b, want %0b", nr, e.none_ready));
      if (ll !== e.lock_level)
        report($sformatf("lock_level %0d, want %0d", ll, e.lock_level));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  in_action;
  logic [3:0]  in_task_id;
  logic [4:0]  in_task_prio;
  logic [15:0] in_delay_ticks;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_next_task;
  logic        out_switch_request;
  logic        out_none_ready;
  logic [7:0]  out_lock_level;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;

  sched_scoreboard sb;
  int cycles;
  int burst_left;
  int gap_max;
  bit hold_kick;

  static_priority_task_scheduler dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_task_id         (in_task_id),
    .in_task_prio       (in_task_prio),
    .in_delay_ticks     (in_delay_ticks),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_next_task      (out_next_task),
    .out_switch_request (out_switch_request),
    .out_none_ready     (out_none_ready),
    .out_lock_level     (out_lock_level),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("static_priority_task_scheduler_tb: done, errors");
      $finish;
    end
  end

  task send(logic [3:0] act, logic [3:0] id, logic [4:0] prio, logic [15:0] ticks);
    in_valid       <= 1'b1;
    in_action      <= act;
    in_task_id     <= id;
    in_task_prio   <= prio;
    in_delay_ticks <= ticks;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(act, id, prio, ticks);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task send_random();
    int r;
    int k;
    logic [3:0]  act;
    logic [15:0] ticks;
    r = $urandom_range(0, 99);
    if (r < 8) act = ACT_CREATE;
    else if (r < 33) act = ACT_TICK;
    else if (r < 48) act = ACT_DELAY;
    else if (r < 60) act = ACT_SUSPEND;
    else if (r < 72) act = ACT_RESUME;
    else if (r < 76) act = ACT_LOCK;
    else if (r < 81) act = ACT_UNLOCK;
    else if (r < 84) act = ACT_UNLOCK_NS;
    else if (r < 87) act = ACT_START;
    else if (r < 96) act = ACT_SCHEDULE;
    else act = 4'($urandom_range(ACT_FIRST_NOOP, ACT_LAST_NOOP));
    ticks = 16'($urandom);
    if (act == ACT_DELAY) begin
      k = $urandom_range(0, 99);
      if (k < 70) ticks = 16'($urandom_range(0, 4));
      else if (k < 99) ticks = 16'($urandom_range(5, 40));
    end
    send(act, 4'($urandom), 5'($urandom), ticks);
  endtask

  task settle_and_write(logic [7:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.slice_len = value;
  endtask

  initial begin
    int hold_left;
    int stall_mode;
    int rx_cycles;
    hold_left = 0;
    stall_mode = 0;
    rx_cycles = 0;
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (rst_n && out_valid && !out_stall)
        sb.check_result(out_next_task, out_switch_request, out_none_ready, out_lock_level);
      if (hold_kick && hold_left == 0) begin
        hold_kick = 0;
        hold_left = HOLD_CYCLES;
      end
      if (rx_cycles % 256 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (rx_cycles % 5 < 2);
        endcase
      end
    end
  end

  initial begin
    logic [7:0] slice_set[4];
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_TICK;
    in_task_id = '0;
    in_task_prio = '0;
    in_delay_ticks = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    cycles = 0;
    hold_kick = 0;
    gap_max = 6;
    burst_left = 5;
    slice_set[0] = 8'd1;
    slice_set[1] = 8'd255;
    slice_set[2] = 8'd3;
    slice_set[3] = 8'($urandom_range(1, 255));
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    settle_and_write(8'd2);
    send(ACT_SCHEDULE,  4'd0,  5'd0,  16'h0000);
    send(ACT_CREATE,    4'd3,  5'd31, 16'hffff);
    send(ACT_CREATE,    4'd15, 5'd0,  16'h0000);
    send(ACT_CREATE,    4'd0,  5'd31, 16'h0000);
    send(ACT_CREATE,    4'd3,  5'd5,  16'h0000);
    send(ACT_START,     4'd0,  5'd0,  16'h0000);
    send(ACT_TICK,      4'd0,  5'd0,  16'h0000);
    send(ACT_DELAY,     4'd0,  5'd0,  16'h0000);
    send(ACT_TICK,      4'd0,  5'd0,  16'h0000);
    send(ACT_SCHEDULE,  4'd0,  5'd0,  16'h0000);
    send(ACT_SUSPEND,   4'd15, 5'd0,  16'h0000);
    send(ACT_SUSPEND,   4'd15, 5'd0,  16'h0000);
    send(ACT_RESUME,    4'd15, 5'd0,  16'h0000);
    send(ACT_RESUME,    4'd15, 5'd0,  16'h0000);
    send(ACT_RESUME,    4'd15, 5'd0,  16'h0000);
    send(ACT_DELAY,     4'd0,  5'd0,  16'd3);
    send(ACT_SUSPEND,   4'd15, 5'd0,  16'h0000);
    send(ACT_LOCK,      4'd0,  5'd0,  16'h0000);
    send(ACT_LOCK,      4'd0,  5'd0,  16'h0000);
    send(ACT_SCHEDULE,  4'd0,  5'd0,  16'h0000);
    send(ACT_UNLOCK_NS, 4'd0,  5'd0,  16'h0000);
    send(ACT_UNLOCK,    4'd0,  5'd0,  16'h0000);
    send(ACT_UNLOCK,    4'd0,  5'd0,  16'h0000);
    send(ACT_UNLOCK_NS, 4'd0,  5'd0,  16'h0000);
    send(ACT_FIRST_NOOP, 4'd7, 5'd9,  16'h1234);
    send(ACT_LAST_NOOP, 4'd0,  5'd0,  16'h0000);
    repeat (4) send(ACT_TICK, 4'd0, 5'd0, 16'h0000);

    repeat (256) send(ACT_LOCK, 4'd0, 5'd0, 16'h0000);
    send(ACT_START, 4'd0, 5'd0, 16'h0000);
    repeat (256) send(ACT_UNLOCK_NS, 4'd0, 5'd0, 16'h0000);
    send(ACT_CREATE, 4'd7, 5'd4, 16'h0000);
    repeat (257) send(ACT_SUSPEND, 4'd7, 5'd0, 16'h0000);
    repeat (256) send(ACT_RESUME, 4'd7, 5'd0, 16'h0000);

    foreach (slice_set[i]) begin
      settle_and_write(slice_set[i]);
      gap_max = (i % 2 == 0) ? 3 : 12;
      if (i == 1) hold_kick = 1;
      repeat (250) send_random();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("static_priority_task_scheduler_tb: done, clean");
    end else begin
      $display("static_priority_task_scheduler_tb: done, errors");
    end
    $finish;
  end

endmodule

[static_priority_task_scheduler.f]
design/sts_pkg.sv
design/sts_ctrl.sv
design/sts_dp.sv
design/static_priority_task_scheduler.sv
sim/static_priority_task_scheduler_tb.sv
